// File: rtl/quaternion_to_euler_angles_unit_assert.svh
// Assertion macros for the quaternion to Euler angle unit
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
// check an implication on every clock edge out of reset
`define Q2E_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// check an implication in the next cycle
`define Q2E_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/q2e_pkg.sv
// Package for the quaternion to Euler angle unit: widths, constants, tables
package q2e_pkg;
  localparam int QuatW      = 16;
  localparam int FovW       = 8;
  localparam int YawW       = 17;
  localparam int PitchW     = 16;
  localparam int RollW      = 15;
  localparam int PoleW      = 2;
  localparam int AccBits    = 22;
  localparam int AngleFrac  = 7;
  localparam int CordicIter = 16;
  localparam int PreShift   = 16;
  localparam int ZW         = 34;
  localparam int CW         = 56;
  localparam int ProdW      = 33;
  localparam int SumW       = 35;
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = 2;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  typedef struct packed {
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  typedef struct packed {
    pole_e                   pole;
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qw;
    logic signed [SumW-1:0]  yaw_y;
    logic signed [SumW-1:0]  yaw_x;
    logic signed [SumW-1:0]  pit_y;
    logic signed [SumW-1:0]  pit_x;
    logic signed [SumW-1:0]  unit;
    logic signed [SumW-1:0]  s2;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0: r = 34'sd188743680;  5'd1: r = 34'sd111421900;
      5'd2: r = 34'sd58872272;   5'd3: r = 34'sd29884485;
      5'd4: r = 34'sd15000234;   5'd5: r = 34'sd7507429;
      5'd6: r = 34'sd3754631;    5'd7: r = 34'sd1877430;
      5'd8: r = 34'sd938729;     5'd9: r = 34'sd469366;
      5'd10: r = 34'sd234683;    5'd11: r = 34'sd117342;
      5'd12: r = 34'sd58671;     5'd13: r = 34'sd29335;
      5'd14: r = 34'sd14668;     5'd15: r = 34'sd7334;
      5'd16: r = 34'sd3667;      5'd17: r = 34'sd1833;
      5'd18: r = 34'sd917;       5'd19: r = 34'sd458;
      5'd20: r = 34'sd229;       5'd21: r = 34'sd115;
      5'd22: r = 34'sd57;        5'd23: r = 34'sd29;
      5'd24: r = 34'sd14;        5'd25: r = 34'sd7;
      5'd26: r = 34'sd4;         5'd27: r = 34'sd2;
      5'd28: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] deg(input int d);
    return ZW'(d) <<< AccBits;
  endfunction
endpackage

// File: rtl/quaternion_to_euler_angles_unit.sv
// Top level of the quaternion to Euler angle unit
//  channel | handshake                 | words
//  item in | start / busy              | quat_x_i quat_y_i quat_z_i quat_w_i
//  config  | cfg_valid_i / cfg_ready_o | cfg_data_i (fov in degrees)
//  result  | done_o strobe             | yaw_angle_o pitch_angle_o roll_angle_o view_fov_o pole_case_o
// One word accepted per cycle; busy stays low, the pipeline never stalls.
// From the start edge to the edge that takes the result an item passes 2 front
// stages, the queue, 2 roll stages, 31 square root stages, 17 CORDIC stages
// and an output register. The receiver cannot stall.
// Reset clears only control state; fov resets to 80 degrees.
module quaternion_to_euler_angles_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_x_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_y_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_z_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_w_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [q2e_pkg::FovW-1:0]          cfg_data_i,
  output logic                              done_o,
  output logic signed [q2e_pkg::YawW-1:0]   yaw_angle_o,
  output logic signed [q2e_pkg::PitchW-1:0] pitch_angle_o,
  output logic signed [q2e_pkg::RollW-1:0]  roll_angle_o,
  output logic [q2e_pkg::FovW-1:0]          view_fov_o,
  output logic [q2e_pkg::PoleW-1:0]         pole_case_o
);
  logic                       f_vld, empty, pop;
  q2e_pkg::item_t             f_item, q_item;
  logic [q2e_pkg::FovW-1:0]   fov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fov_q <= 8'd80;
    else if (cfg_valid_i && cfg_ready_o) fov_q <= cfg_data_i;
  end

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign pop         = !empty;

  q2e_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_vld_i(start),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i), .quat_z_i(quat_z_i), .quat_w_i(quat_w_i),
    .out_vld_o(f_vld), .item_o(f_item)
  );

  q2e_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(f_vld), .wdata_i(f_item),
    .pop_i(pop), .empty_o(empty), .rdata_o(q_item)
  );

  q2e_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_vld_i(pop), .item_i(q_item),
    .done_o(done_o), .yaw_o(yaw_angle_o), .pitch_o(pitch_angle_o),
    .roll_o(roll_angle_o), .pole_o(pole_case_o)
  );

  assign view_fov_o = fov_q;
endmodule

// File: rtl/q2e_front.sv
// Front end: products, sums of squares and pole classification
module q2e_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_x_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_y_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_z_i,
  input  logic signed [q2e_pkg::QuatW-1:0]  quat_w_i,
  output logic                              out_vld_o,
  output q2e_pkg::item_t                    item_o
);
  localparam int SW = q2e_pkg::SumW;
  localparam int PW = q2e_pkg::ProdW;

  logic                    v1_q, v2_q;
  logic signed [PW-1:0]    xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, yw_q, xz_q, xw_q, yz_q;
  logic signed [q2e_pkg::QuatW-1:0] qx_q, qw_q;
  q2e_pkg::item_t          item_d, item_q;
  logic signed [SW-1:0]    unit, test;
  logic signed [SW+10:0]   lhs, rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= PW'(quat_x_i) * PW'(quat_x_i);
    yy_q <= PW'(quat_y_i) * PW'(quat_y_i);
    zz_q <= PW'(quat_z_i) * PW'(quat_z_i);
    ww_q <= PW'(quat_w_i) * PW'(quat_w_i);
    xy_q <= PW'(quat_x_i) * PW'(quat_y_i);
    zw_q <= PW'(quat_z_i) * PW'(quat_w_i);
    yw_q <= PW'(quat_y_i) * PW'(quat_w_i);
    xz_q <= PW'(quat_x_i) * PW'(quat_z_i);
    xw_q <= PW'(quat_x_i) * PW'(quat_w_i);
    yz_q <= PW'(quat_y_i) * PW'(quat_z_i);
    qx_q <= quat_x_i;
    qw_q <= quat_w_i;
    item_q <= item_d;
  end

  always_comb begin
    unit = SW'(xx_q) + SW'(yy_q) + SW'(zz_q) + SW'(ww_q);
    test = SW'(xy_q) + SW'(zw_q);
    lhs  = (SW+11)'(test) * (SW+11)'(1000);
    rhs  = (SW+11)'(unit) * (SW+11)'(499);
    item_d.qx    = qx_q;
    item_d.qw    = qw_q;
    item_d.unit  = unit;
    item_d.s2    = test <<< 1;
    item_d.yaw_y = (SW'(yw_q) - SW'(xz_q)) <<< 1;
    item_d.yaw_x = SW'(xx_q) - SW'(yy_q) - SW'(zz_q) + SW'(ww_q);
    item_d.pit_y = (SW'(xw_q) - SW'(yz_q)) <<< 1;
    item_d.pit_x = -SW'(xx_q) + SW'(yy_q) - SW'(zz_q) + SW'(ww_q);
    if (lhs > rhs) begin
      item_d.pole = q2e_pkg::POLE_NORTH;
    end else if (lhs < -rhs) begin
      item_d.pole = q2e_pkg::POLE_SOUTH;
    end else begin
      item_d.pole = q2e_pkg::POLE_NONE;
    end
  end

  assign out_vld_o = v2_q;
  assign item_o    = item_q;
endmodule

// File: rtl/q2e_fifo.sv
// Short queue between front and back end
module q2e_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  q2e_pkg::item_t wdata_i,
  input  logic           pop_i,
  output logic           empty_o,
  output q2e_pkg::item_t rdata_o
);
  localparam int Aw = q2e_pkg::FifoAw;

  q2e_pkg::item_t mem_q [q2e_pkg::FifoDepth];
  logic [Aw-1:0]  wp_q, rp_q;
  logic [Aw:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
endmodule

// File: rtl/q2e_isqrt.sv
// Pipelined integer square root, one result bit per stage
module q2e_isqrt (
  input  logic        clk_i,
  input  logic [61:0] rad_i,
  output logic [30:0] root_o
);
  localparam int N = 31;

  logic [63:0] rem_q [N];
  logic [30:0] r_q   [N];
  logic [63:0] rem_in [N];
  logic [30:0] r_in   [N];
  logic [63:0] trial  [N];

  always_comb begin
    rem_in[0] = {2'b00, rad_i};
    r_in[0]   = '0;
    for (int k = 1; k < N; k++) begin
      rem_in[k] = rem_q[k-1];
      r_in[k]   = r_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = {31'b0, r_in[k], 2'b01} << (2 * (N - 1 - k));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (rem_in[k] >= trial[k]) begin
        rem_q[k] <= rem_in[k] - trial[k];
        r_q[k]   <= {r_in[k][29:0], 1'b1};
      end else begin
        rem_q[k] <= rem_in[k];
        r_q[k]   <= {r_in[k][29:0], 1'b0};
      end
    end
  end

  assign root_o = r_q[N-1];
endmodule

// File: rtl/q2e_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in 2^-22 degree
module q2e_cordic (
  input  logic                             clk_i,
  input  q2e_pkg::vec_t                    vec_i,
  output logic signed [q2e_pkg::ZW-1:0]    ang_o
);
  localparam int N  = q2e_pkg::CordicIter;
  localparam int W  = q2e_pkg::CW;
  localparam int ZW = q2e_pkg::ZW;

  logic signed [W-1:0]  x_q [N+1];
  logic signed [W-1:0]  y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 zero_q [N+1];

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (vec_i.x == '0) && (vec_i.y == '0);
    if (vec_i.x < 0) begin
      x_q[0] <= -(vec_i.x <<< q2e_pkg::PreShift);
      y_q[0] <= -(vec_i.y <<< q2e_pkg::PreShift);
      z_q[0] <= (vec_i.y >= 0) ? q2e_pkg::deg(180) : -q2e_pkg::deg(180);
    end else begin
      x_q[0] <= vec_i.x <<< q2e_pkg::PreShift;
      y_q[0] <= vec_i.y <<< q2e_pkg::PreShift;
      z_q[0] <= '0;
    end
    for (int i = 0; i < N; i++) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + q2e_pkg::atan_tab(5'(i));
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - q2e_pkg::atan_tab(5'(i));
      end
    end
  end

  assign ang_o = zero_q[N] ? '0 : z_q[N];
endmodule

// File: rtl/q2e_back.sv
// Back end: roll prescale, square root, three CORDICs, rounding
module q2e_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  input  q2e_pkg::item_t                    item_i,
  output logic                              done_o,
  output logic signed [q2e_pkg::YawW-1:0]   yaw_o,
  output logic signed [q2e_pkg::PitchW-1:0] pitch_o,
  output logic signed [q2e_pkg::RollW-1:0]  roll_o,
  output logic [q2e_pkg::PoleW-1:0]         pole_o
);
  localparam int SW   = q2e_pkg::SumW;
  localparam int CW   = q2e_pkg::CW;
  localparam int ZW   = q2e_pkg::ZW;
  localparam int SqL  = 31;
  localparam int CoL  = q2e_pkg::CordicIter;
  localparam int Lat  = 3 + SqL + CoL;

  logic [Lat:0]          v_q;
  q2e_pkg::item_t        it_q;
  logic signed [SW-1:0]  u_q, s_q;
  logic [61:0]           rad_q;
  logic [30:0]           root;
  logic signed [SW-1:0]  u1, s1;
  logic signed [SW-1:0]  sd   [SqL+1];
  q2e_pkg::item_t        itd  [SqL+1];
  q2e_pkg::vec_t         vy, vp, vr;
  logic signed [ZW-1:0]  ay, ap, ar;
  q2e_pkg::pole_e        pd   [CoL+1];
  logic signed [ZW+1:0]  yz, pz, rz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[Lat-1:0], in_vld_i};
  end

  always_comb begin
    u1 = item_i.unit;
    s1 = item_i.s2;
    for (int k = 0; k < 4; k++) begin
      if (u1 >= (SW'(1) <<< 31)) begin
        u1 = u1 >>> 1;
        s1 = s1 >>> 1;
      end
    end
    if (s1 > u1) s1 = u1;
    if (s1 < -u1) s1 = -u1;
  end

  always_ff @(posedge clk_i) begin
    it_q  <= item_i;
    u_q   <= u1;
    s_q   <= s1;
    rad_q <= 62'(u_q - s_q) * 62'(u_q + s_q);
    itd[0] <= it_q;
    sd[0]  <= s_q;
    for (int k = 0; k < SqL; k++) begin
      itd[k+1] <= itd[k];
      sd[k+1]  <= sd[k];
    end
    pd[0] <= itd[SqL].pole;
    for (int k = 0; k < CoL; k++) begin
      pd[k+1] <= pd[k];
    end
  end

  q2e_isqrt u_sqrt (.clk_i(clk_i), .rad_i(rad_q), .root_o(root));

  always_comb begin
    vy.y = CW'(itd[SqL].yaw_y);
    vy.x = CW'(itd[SqL].yaw_x);
    vp.y = CW'(itd[SqL].pit_y);
    vp.x = CW'(itd[SqL].pit_x);
    vr.y = CW'(sd[SqL]);
    vr.x = CW'({1'b0, root});
    if (itd[SqL].pole != q2e_pkg::POLE_NONE) begin
      vy.y = CW'(itd[SqL].qx);
      vy.x = CW'(itd[SqL].qw);
    end
  end

  q2e_cordic u_cy (.clk_i(clk_i), .vec_i(vy), .ang_o(ay));
  q2e_cordic u_cp (.clk_i(clk_i), .vec_i(vp), .ang_o(ap));
  q2e_cordic u_cr (.clk_i(clk_i), .vec_i(vr), .ang_o(ar));

  function automatic logic signed [ZW+1:0] fin(input logic signed [ZW+1:0] z,
                                               input logic signed [ZW+1:0] lim);
    logic signed [ZW+1:0] v;
    v = (z + (ZW+2)'(1 <<< 14)) >>> 15;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  always_comb begin
    unique case (pd[CoL])
      q2e_pkg::POLE_NORTH: begin
        yz = -((ZW+2)'(ay) <<< 1);
        pz = '0;
        rz = (ZW+2)'(q2e_pkg::deg(90));
      end
      q2e_pkg::POLE_SOUTH: begin
        yz = (ZW+2)'(ay) <<< 1;
        pz = '0;
        rz = -(ZW+2)'(q2e_pkg::deg(90));
      end
      default: begin
        yz = -(ZW+2)'(ay);
        pz = -(ZW+2)'(ap);
        rz = (ZW+2)'(ar);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    yaw_o   <= q2e_pkg::YawW'(fin(yz, (ZW+2)'(46080)));
    pitch_o <= q2e_pkg::PitchW'(fin(pz, (ZW+2)'(23040)));
    roll_o  <= q2e_pkg::RollW'(fin(rz, (ZW+2)'(11520)));
    pole_o  <= pd[CoL];
  end

  assign done_o = v_q[Lat];
endmodule

// File: rtl/q2e_checker.sv
// Port checker for the quaternion to Euler angle unit
`include "quaternion_to_euler_angles_unit_assert.svh"
module q2e_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               busy_i,
  input logic                               done_i,
  input logic [q2e_pkg::PoleW-1:0]          pole_i,
  input logic signed [q2e_pkg::RollW-1:0]   roll_i,
  input logic signed [q2e_pkg::PitchW-1:0]  pitch_i
);
  `Q2E_ASSERT_IMP(a_pole_code, clk_i, rst_ni, done_i,
    (pole_i == q2e_pkg::POLE_NONE) || (pole_i == q2e_pkg::POLE_NORTH) ||
    (pole_i == q2e_pkg::POLE_SOUTH), "bad pole code")
  `Q2E_ASSERT_IMP(a_north, clk_i, rst_ni, done_i && (pole_i == q2e_pkg::POLE_NORTH),
    (roll_i == 15'sd11520) && (pitch_i == 16'sd0), "north pole result")
  `Q2E_ASSERT_IMP(a_south, clk_i, rst_ni, done_i && (pole_i == q2e_pkg::POLE_SOUTH),
    (roll_i == -15'sd11520) && (pitch_i == 16'sd0), "south pole result")
  `Q2E_ASSERT_NXT(a_busy, clk_i, rst_ni, 1'b1, !busy_i, "busy raised")
endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy_i(busy), .done_i(done_o),
  .pole_i(pole_case_o), .roll_i(roll_angle_o), .pitch_i(pitch_angle_o)
);
